@@ rtl/core/song_position_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Song position sequencer assertion macros
// Shared property templates for the sequencer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SONG_POSITION_SEQUENCER_DEFINES_SVH
`define SONG_POSITION_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// Song position sequencer package
// Widths, operation and register codes, and the shared structs.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int MAX_FRAMES = 1024;
	localparam int MAX_ROWS   = 256;

	localparam int FRAME_W  = $clog2(MAX_FRAMES);
	localparam int FCOUNT_W = FRAME_W + 1;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int PHRASE_W = ROW_W + 1;
	localparam int TICK_W   = 8;
	localparam int ARG_W    = 8;
	localparam int OP_W     = 3;

	localparam logic [TICK_W-1:0]   GROOVE_RESET = TICK_W'(6);
	localparam logic [PHRASE_W-1:0] PHRASE_RESET = PHRASE_W'(64);
	localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(1);
	localparam logic [FCOUNT_W-1:0] LOOP_RESET   = '1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_BREAK    = 3'd1,
		OP_SET_EVEN = 3'd2,
		OP_SET_ODD  = 3'd3,
		OP_START    = 3'd4,
		OP_STOP     = 3'd5
	} sps_op_t;

	typedef enum logic [2:0] {
		REG_GROOVE_EVEN = 3'd0,
		REG_GROOVE_ODD  = 3'd1,
		REG_PHRASE_LEN  = 3'd2,
		REG_FRAME_COUNT = 3'd3,
		REG_LOOP_FRAME  = 3'd4
	} sps_reg_t;

	typedef struct packed {
		logic [TICK_W-1:0]          groove_even_default;
		logic [TICK_W-1:0]          groove_odd_default;
		logic [PHRASE_W-1:0]        rows_per_phrase;
		logic [FCOUNT_W-1:0]        frame_count;
		logic signed [FCOUNT_W-1:0] loop_frame;
	} sps_cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [ARG_W-1:0]   argument;
		logic [FRAME_W-1:0] start_frame;
		logic               hold_frame;
	} sps_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_now;
		logic [ROW_W-1:0]   row_now;
		logic [TICK_W-1:0]  tick_now;
		logic               is_playing;
		logic               row_begins;
	} sps_pos_t;

endpackage

@@ rtl/core/song_position_sequencer.sv @@
// ----------------------------------------------------------------------------
// Song position sequencer
// Tracker playback position: tick, row and frame counters driven by events.
// ----------------------------------------------------------------------------
// Each input transaction carries one event (tick, break, groove set, start or
// stop) and produces exactly one output transaction reporting frame, row and
// tick after that event. The block accepts one transaction per clock: an
// input register feeds a single pass of counter updates whose result lands in
// an output register; the rate is one item per cycle, limited only by the
// output side's tready. Configuration must be written over APB only while no
// transaction is in flight; the block itself does not enforce this.
module song_position_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] argument, [17:8] start_frame, [18] hold_frame, [23:19] zero
	input  logic [23:0] s_tdata,
	// [2:0] operation
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] frame_now, [17:10] row_now, [25:18] tick_now, [26] is_playing,
	// [27] row_begins, [31:28] zero
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sps_pkg::*;

	sps_cfg_t  cfg;
	sps_item_t item_s1;
	logic      valid_s1;
	sps_pos_t  pos_next;
	sps_pos_t  pos_s2;
	logic      valid_s2;
	logic      step;
	logic      out_free;

	sps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !valid_s2 || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation   <= s_tuser;
			item_s1.argument    <= s_tdata[7:0];
			item_s1.start_frame <= s_tdata[17:8];
			item_s1.hold_frame  <= s_tdata[18];
		end
	end

	sps_pos_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.cfg      (cfg),
		.pos_next (pos_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pos_s2 <= pos_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0, pos_s2.row_begins, pos_s2.is_playing, pos_s2.tick_now,
		pos_s2.row_now, pos_s2.frame_now};

endmodule

@@ rtl/core/sps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Song position sequencer configuration registers
// APB register file holding grooves, phrase length, frame count and loop frame.
// ----------------------------------------------------------------------------
module sps_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output sps_pkg::sps_cfg_t cfg
);
	import sps_pkg::*;

	sps_cfg_t cfg_q;
	logic     wr_en;
	sps_reg_t reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = sps_reg_t'(paddr[4:2]);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.groove_even_default <= GROOVE_RESET;
			cfg_q.groove_odd_default  <= GROOVE_RESET;
			cfg_q.rows_per_phrase     <= PHRASE_RESET;
			cfg_q.frame_count         <= FCOUNT_RESET;
			cfg_q.loop_frame          <= LOOP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GROOVE_EVEN: cfg_q.groove_even_default <= pwdata[TICK_W-1:0];
				REG_GROOVE_ODD:  cfg_q.groove_odd_default  <= pwdata[TICK_W-1:0];
				REG_PHRASE_LEN:  cfg_q.rows_per_phrase     <= pwdata[PHRASE_W-1:0];
				REG_FRAME_COUNT: cfg_q.frame_count         <= pwdata[FCOUNT_W-1:0];
				REG_LOOP_FRAME:  cfg_q.loop_frame          <= pwdata[FCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_GROOVE_EVEN: prdata = 32'(cfg_q.groove_even_default);
			REG_GROOVE_ODD:  prdata = 32'(cfg_q.groove_odd_default);
			REG_PHRASE_LEN:  prdata = 32'(cfg_q.rows_per_phrase);
			REG_FRAME_COUNT: prdata = 32'(cfg_q.frame_count);
			REG_LOOP_FRAME:  prdata = 32'(unsigned'(cfg_q.loop_frame));
			default:         prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/sps_pos_engine.sv @@
// ----------------------------------------------------------------------------
// Song position sequencer position engine
// Playback state registers and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
`include "song_position_sequencer_defines.svh"

module sps_pos_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  sps_pkg::sps_item_t item,
	input  sps_pkg::sps_cfg_t  cfg,
	output sps_pkg::sps_pos_t  pos_next
);
	import sps_pkg::*;

	logic [TICK_W-1:0]  tick_q, tick_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [FRAME_W-1:0] frame_q, frame_d;
	logic               break_pending_q, break_pending_d;
	logic [ROW_W-1:0]   break_row_q, break_row_d;
	logic [TICK_W-1:0]  groove_even_q, groove_even_d;
	logic [TICK_W-1:0]  groove_odd_q, groove_odd_d;
	logic               running_q, running_d;
	logic               repeat_q, repeat_d;

	logic [PHRASE_W-1:0] eff_phrase;
	logic [FCOUNT_W-1:0] eff_fcount;
	logic [TICK_W-1:0]   groove;
	logic [TICK_W:0]     tick_inc;
	logic [ROW_W:0]      row_inc;
	logic [FCOUNT_W-1:0] frame_adv;
	logic [FCOUNT_W-1:0] last_frame;

	// Oversized phrase lengths and frame counts saturate; a zero frame count acts as one.
	always_comb begin
		if (cfg.rows_per_phrase > PHRASE_W'(MAX_ROWS))
			eff_phrase = PHRASE_W'(MAX_ROWS);
		else
			eff_phrase = cfg.rows_per_phrase;
		if (cfg.frame_count == '0)
			eff_fcount = FCOUNT_W'(1);
		else if (cfg.frame_count > FCOUNT_W'(MAX_FRAMES))
			eff_fcount = FCOUNT_W'(MAX_FRAMES);
		else
			eff_fcount = cfg.frame_count;
	end

	assign groove     = row_q[0] ? groove_odd_q : groove_even_q;
	assign tick_inc   = {1'b0, tick_q} + 1'b1;
	assign row_inc    = {1'b0, row_q} + 1'b1;
	assign frame_adv  = repeat_q ? {1'b0, frame_q} : {1'b0, frame_q} + 1'b1;
	assign last_frame = eff_fcount - 1'b1;

	always_comb begin
		tick_d          = tick_q;
		row_d           = row_q;
		frame_d         = frame_q;
		break_pending_d = break_pending_q;
		break_row_d     = break_row_q;
		groove_even_d   = groove_even_q;
		groove_odd_d    = groove_odd_q;
		running_d       = running_q;
		repeat_d        = repeat_q;
		case (sps_op_t'(item.operation))
			OP_TICK: begin
				if (running_q) begin
					if (tick_inc < {1'b0, groove}) begin
						tick_d = tick_inc[TICK_W-1:0];
					end else begin
						tick_d = '0;
						if ((PHRASE_W'(row_inc) < eff_phrase) && !break_pending_q) begin
							row_d = row_inc[ROW_W-1:0];
						end else begin
							row_d           = break_pending_q ? break_row_q : '0;
							break_pending_d = 1'b0;
							if (frame_adv >= eff_fcount) begin
								// Past the last frame: a negative loop frame stops playback.
								if (cfg.loop_frame[FCOUNT_W-1]) begin
									running_d = 1'b0;
									frame_d   = '0;
								end else begin
									frame_d = cfg.loop_frame[FRAME_W-1:0];
								end
							end else begin
								frame_d = frame_adv[FRAME_W-1:0];
							end
						end
					end
				end
			end
			OP_BREAK: begin
				break_row_d     = item.argument;
				break_pending_d = PHRASE_W'(item.argument) < eff_phrase;
			end
			OP_SET_EVEN: groove_even_d = item.argument;
			OP_SET_ODD:  groove_odd_d  = item.argument;
			OP_START: begin
				if (FCOUNT_W'(item.start_frame) >= eff_fcount)
					frame_d = last_frame[FRAME_W-1:0];
				else
					frame_d = item.start_frame;
				repeat_d        = item.hold_frame;
				row_d           = '0;
				tick_d          = '0;
				break_pending_d = 1'b0;
				groove_even_d   = cfg.groove_even_default;
				groove_odd_d    = cfg.groove_odd_default;
				running_d       = 1'b1;
			end
			OP_STOP: running_d = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		pos_next.frame_now  = frame_d;
		pos_next.row_now    = row_d;
		pos_next.tick_now   = tick_d;
		pos_next.is_playing = running_d;
		pos_next.row_begins = running_d && (tick_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q          <= '0;
			row_q           <= '0;
			frame_q         <= '0;
			break_pending_q <= 1'b0;
			break_row_q     <= '0;
			groove_even_q   <= '0;
			groove_odd_q    <= '0;
			running_q       <= 1'b0;
			repeat_q        <= 1'b0;
		end else if (step) begin
			tick_q          <= tick_d;
			row_q           <= row_d;
			frame_q         <= frame_d;
			break_pending_q <= break_pending_d;
			break_row_q     <= break_row_d;
			groove_even_q   <= groove_even_d;
			groove_odd_q    <= groove_odd_d;
			running_q       <= running_d;
			repeat_q        <= repeat_d;
		end
	end

	// The counter only survives a tick while below a groove of at most 255.
	`SPS_ASSERT_SAME(a_tick_bound, 1'b1, tick_q != '1, "tick counter reached all ones")
	`SPS_ASSERT_NEXT(a_idle_tick, step && (item.operation == OP_TICK) && !running_q,
		$stable(frame_q) && $stable(row_q) && $stable(tick_q) && !running_q,
		"tick while stopped changed the position")
	`SPS_ASSERT_NEXT(a_start, step && (item.operation == OP_START),
		running_q && (row_q == '0) && (tick_q == '0) && !break_pending_q,
		"start did not rewind the position")
	`SPS_ASSERT_NEXT(a_stop, step && (item.operation == OP_STOP), !running_q,
		"stop left playback running")

endmodule

@@ tb/tb_song_position_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Song position sequencer testbench
// Drives event transactions with bursty valid and a stalling receiver, keeps
// its own model of the tick, row and frame counters, and checks every output
// transaction against it or a typed expectation. A short directed script comes
// first, then random playback phases, each under freshly written registers.
// ----------------------------------------------------------------------------
module tb_song_position_sequencer;
	import sps_pkg::*;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam logic [2:0] OP_UNUSED6 = 3'd6;
	localparam logic [2:0] OP_UNUSED7 = 3'd7;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	song_position_sequencer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// Shadow registers and playback state.
	logic [7:0]  cfg_even_def = GROOVE_RESET;
	logic [7:0]  cfg_odd_def  = GROOVE_RESET;
	logic [8:0]  cfg_phrase   = PHRASE_RESET;
	logic [10:0] cfg_frames   = FCOUNT_RESET;
	logic [10:0] cfg_loop     = LOOP_RESET;

	logic [7:0] tick_cnt    = '0;
	logic [7:0] row_idx     = '0;
	logic [9:0] frame_idx   = '0;
	logic       brk_pending = 1'b0;
	logic [7:0] brk_row     = '0;
	logic [7:0] grv_even    = '0;
	logic [7:0] grv_odd     = '0;
	logic       playing     = 1'b0;
	logic       hold_same   = 1'b0;

	sps_pos_t positions_due[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	bit tx_high = 1'b0;

	typedef struct {
		bit          is_cfg;
		sps_reg_t    reg_sel;
		logic [31:0] cfg_val;
		logic [2:0]  op;
		logic [7:0]  arg;
		logic [9:0]  sf;
		logic        hold;
		bit          typed;
		sps_pos_t    want;
	} stim_row_t;

	stim_row_t directed_rows[$];

	function automatic sps_pos_t play_event(input logic [2:0] op, input logic [7:0] arg,
			input logic [9:0] sf, input logic hold);
		logic [8:0]  phrase_eff;
		logic [10:0] frames_eff;
		logic [7:0]  groove;
		logic [8:0]  tick_nxt;
		logic [8:0]  row_nxt;
		logic [10:0] frame_nxt;
		sps_pos_t    pos;
		phrase_eff = (cfg_phrase > 9'd256) ? 9'd256 : cfg_phrase;
		frames_eff = (cfg_frames == 11'd0) ? 11'd1 :
			((cfg_frames > 11'd1024) ? 11'd1024 : cfg_frames);
		case (op)
			OP_TICK: begin
				if (playing) begin
					groove   = row_idx[0] ? grv_odd : grv_even;
					tick_nxt = {1'b0, tick_cnt} + 9'd1;
					if (tick_nxt < {1'b0, groove}) begin
						tick_cnt = tick_nxt[7:0];
					end else begin
						tick_cnt = '0;
						row_nxt  = {1'b0, row_idx} + 9'd1;
						if (row_nxt < phrase_eff && !brk_pending) begin
							row_idx = row_nxt[7:0];
						end else begin
							if (brk_pending) begin
								row_idx     = brk_row;
								brk_pending = 1'b0;
							end else begin
								row_idx = '0;
							end
							frame_nxt = {1'b0, frame_idx} + (hold_same ? 11'd0 : 11'd1);
							// Past the last frame: a negative loop target ends playback.
							if (frame_nxt >= frames_eff) begin
								if (cfg_loop[10]) begin
									playing   = 1'b0;
									frame_idx = '0;
								end else begin
									frame_idx = cfg_loop[9:0];
								end
							end else begin
								frame_idx = frame_nxt[9:0];
							end
						end
					end
				end
			end
			OP_BREAK: begin
				brk_row     = arg;
				brk_pending = ({1'b0, arg} < phrase_eff);
			end
			OP_SET_EVEN: grv_even = arg;
			OP_SET_ODD:  grv_odd  = arg;
			OP_START: begin
				frame_idx   = ({1'b0, sf} >= frames_eff) ? 10'(frames_eff - 11'd1) : sf;
				hold_same   = hold;
				row_idx     = '0;
				tick_cnt    = '0;
				brk_pending = 1'b0;
				grv_even    = cfg_even_def;
				grv_odd     = cfg_odd_def;
				playing     = 1'b1;
			end
			OP_STOP: playing = 1'b0;
			default: ;
		endcase
		pos.frame_now  = frame_idx;
		pos.row_now    = row_idx;
		pos.tick_now   = tick_cnt;
		pos.is_playing = playing;
		pos.row_begins = playing && (tick_cnt == 8'd0);
		return pos;
	endfunction

	// Sends one event and records what the block must report for it.
	task automatic push_item(input logic [2:0] op, input logic [7:0] arg, input logic [9:0] sf,
			input logic hold, input bit typed, input sps_pos_t want);
		sps_pos_t pred;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, hold, sf, arg};
		tx_high  = 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = play_event(op, arg, sf, hold);
		positions_due.push_back(typed ? want : pred);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			tx_high  = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	// Holds off the sender until every outstanding transaction has come back.
	task automatic drain_outputs();
		if (tx_high) begin
			s_tvalid <= 1'b0;
			tx_high  = 1'b0;
		end
		while (positions_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input sps_reg_t r, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (r)
			REG_GROOVE_EVEN: cfg_even_def = v[7:0];
			REG_GROOVE_ODD:  cfg_odd_def  = v[7:0];
			REG_PHRASE_LEN:  cfg_phrase   = v[8:0];
			REG_FRAME_COUNT: cfg_frames   = v[10:0];
			REG_LOOP_FRAME:  cfg_loop     = v[10:0];
			default: ;
		endcase
	endtask

	task automatic add_evt(input logic [2:0] op, input logic [7:0] arg, input logic [9:0] sf,
			input logic hold);
		stim_row_t row;
		row        = '{reg_sel: REG_GROOVE_EVEN, default: '0};
		row.op     = op;
		row.arg    = arg;
		row.sf     = sf;
		row.hold   = hold;
		directed_rows.push_back(row);
	endtask

	task automatic add_chk(input logic [2:0] op, input logic [7:0] arg, input logic [9:0] sf,
			input logic hold, input int frame, input int row_n, input int tick,
			input bit play, input bit begins);
		stim_row_t row;
		row                 = '{reg_sel: REG_GROOVE_EVEN, default: '0};
		row.op              = op;
		row.arg             = arg;
		row.sf              = sf;
		row.hold            = hold;
		row.typed           = 1'b1;
		row.want.frame_now  = 10'(frame);
		row.want.row_now    = 8'(row_n);
		row.want.tick_now   = 8'(tick);
		row.want.is_playing = play;
		row.want.row_begins = begins;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg(input sps_reg_t r, input logic [31:0] v);
		stim_row_t row;
		row         = '{reg_sel: REG_GROOVE_EVEN, default: '0};
		row.is_cfg  = 1'b1;
		row.reg_sel = r;
		row.cfg_val = v;
		directed_rows.push_back(row);
	endtask

	task automatic run_song_phase(input int n_items);
		logic [2:0]  op;
		logic [7:0]  arg;
		logic [9:0]  sf;
		logic        hold;
		logic [31:0] v;
		int unsigned pick;
		drain_outputs();
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 255;
			2: v = $urandom_range(0, 255);
			default: v = $urandom_range(0, 3);
		endcase
		apb_write(REG_GROOVE_EVEN, v);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 255;
			2: v = $urandom_range(0, 255);
			default: v = $urandom_range(0, 3);
		endcase
		apb_write(REG_GROOVE_ODD, v);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 256;
			2: v = $urandom_range(0, 511);
			default: v = $urandom_range(1, 6);
		endcase
		apb_write(REG_PHRASE_LEN, v);
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 1024;
			2: v = $urandom_range(0, 2047);
			default: v = $urandom_range(1, 5);
		endcase
		apb_write(REG_FRAME_COUNT, v);
		case ($urandom_range(0, 9))
			0, 1, 2: v = 32'h400 | $urandom_range(0, 1023);
			3: v = $urandom_range(0, 2047);
			default: v = $urandom_range(0, 6);
		endcase
		apb_write(REG_LOOP_FRAME, v);

		for (int k = 0; k < n_items; k++) begin
			arg  = 8'($urandom);
			sf   = 10'($urandom);
			hold = 1'($urandom);
			pick = $urandom_range(0, 99);
			if (k == 0 || (!playing && pick < 25) || (pick >= 88 && pick < 91)) begin
				op = OP_START;
				if ($urandom_range(0, 3) != 0) sf = 10'($urandom_range(0, 7));
				hold = ($urandom_range(0, 4) == 0);
			end else if (pick < 70) begin
				op = OP_TICK;
			end else if (pick < 78) begin
				op = OP_BREAK;
				if ($urandom_range(0, 3) != 0) arg = 8'($urandom_range(0, 7));
			end else if (pick < 88) begin
				op = (pick < 83) ? OP_SET_EVEN : OP_SET_ODD;
				if ($urandom_range(0, 3) != 0) arg = 8'($urandom_range(0, 3));
			end else if (pick < 95) begin
				op = OP_STOP;
			end else begin
				op = (pick < 97) ? OP_UNUSED6 : OP_UNUSED7;
			end
			push_item(op, arg, sf, hold, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : output_monitor
		sps_pos_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (positions_due.size() == 0) begin
				$error("output transaction with no event outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = positions_due.pop_front();
				check_field("frame_now", want.frame_now, m_tdata[9:0]);
				check_field("row_now", want.row_now, m_tdata[17:10]);
				check_field("tick_now", want.tick_now, m_tdata[25:18]);
				check_field("is_playing", want.is_playing, m_tdata[26]);
				check_field("row_begins", want.row_begins, m_tdata[27]);
			end
		end
	end

	// Receiver: a rotating stall pattern, replaced now and then; some patterns never stall.
	logic [15:0] rx_pat = '1;
	int unsigned rx_hold = 0;

	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_hold <= $urandom_range(30, 120);
			rx_pat  <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		end else begin
			rx_hold <= rx_hold - 1;
			rx_pat  <= {rx_pat[0], rx_pat[15:1]};
		end
		m_tready <= rx_pat[0];
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// Stopped block: ticks, unused opcodes, break and groove events.
		add_chk(OP_TICK, 8'd0, 10'd0, 1'b0, 0, 0, 0, 0, 0);
		add_chk(OP_UNUSED6, 8'd0, 10'd0, 1'b0, 0, 0, 0, 0, 0);
		add_chk(OP_UNUSED7, 8'd255, 10'd1023, 1'b1, 0, 0, 0, 0, 0);
		add_evt(OP_BREAK, 8'd3, 10'd0, 1'b0);
		add_evt(OP_SET_EVEN, 8'd0, 10'd0, 1'b0);
		// Zero groove on even rows, short phrase, loop back to frame 1.
		add_cfg(REG_GROOVE_EVEN, 0);
		add_cfg(REG_GROOVE_ODD, 1);
		add_cfg(REG_PHRASE_LEN, 4);
		add_cfg(REG_FRAME_COUNT, 3);
		add_cfg(REG_LOOP_FRAME, 1);
		add_chk(OP_START, 8'd0, 10'd1023, 1'b0, 2, 0, 0, 1, 1);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_BREAK, 8'd255, 10'd0, 1'b0);
		add_evt(OP_BREAK, 8'd2, 10'd0, 1'b0);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_SET_ODD, 8'd255, 10'd0, 1'b0);
		add_evt(OP_SET_EVEN, 8'd255, 10'd0, 1'b0);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_STOP, 8'd0, 10'd0, 1'b0);
		// Oversized phrase and frame count are capped.
		add_cfg(REG_GROOVE_EVEN, 255);
		add_cfg(REG_GROOVE_ODD, 0);
		add_cfg(REG_PHRASE_LEN, 511);
		add_cfg(REG_FRAME_COUNT, 2047);
		add_cfg(REG_LOOP_FRAME, 1023);
		add_chk(OP_START, 8'd0, 10'd1023, 1'b1, 1023, 0, 0, 1, 1);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		// Zero phrase and zero frame count, stop at the end.
		add_cfg(REG_GROOVE_EVEN, 0);
		add_cfg(REG_GROOVE_ODD, 0);
		add_cfg(REG_PHRASE_LEN, 0);
		add_cfg(REG_FRAME_COUNT, 0);
		add_cfg(REG_LOOP_FRAME, 2047);
		add_chk(OP_START, 8'd0, 10'd5, 1'b0, 0, 0, 0, 1, 1);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		// Loop target beyond the frame count keeps wrapping to itself.
		add_cfg(REG_PHRASE_LEN, 1);
		add_cfg(REG_FRAME_COUNT, 4);
		add_cfg(REG_LOOP_FRAME, 600);
		add_chk(OP_START, 8'd0, 10'd3, 1'b0, 3, 0, 0, 1, 1);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);
		add_cfg(REG_LOOP_FRAME, 1024);
		add_evt(OP_TICK, 8'd0, 10'd0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				drain_outputs();
				apb_write(directed_rows[i].reg_sel, directed_rows[i].cfg_val);
			end else begin
				push_item(directed_rows[i].op, directed_rows[i].arg, directed_rows[i].sf,
					directed_rows[i].hold, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int p = 0; p < 10; p++) run_song_phase(40);

		drain_outputs();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ song_position_sequencer.f @@
+incdir+rtl/core
rtl/core/sps_pkg.sv
rtl/core/sps_cfg_regs.sv
rtl/core/sps_pos_engine.sv
rtl/core/song_position_sequencer.sv
tb/tb_song_position_sequencer.sv
